@@ rtl/bsgq_pkg.sv @@
// Shared types, constants and codes for the bitmask spatial grid query block.
`default_nettype none
package bsgq_pkg;

   // Fixed geometry of an actor mask.
   localparam int WORD_BITS    = 64;
   localparam int BLOCKS       = 4;
   localparam int BLK_W        = 2;
   localparam int BIT_W        = 6;
   localparam int CAPACITY     = BLOCKS * WORD_BITS;
   localparam int COORD_W      = 16;
   localparam int GRID_CELLS_D = 64;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_X_LOW     = 3'd0;
   localparam logic [2:0] REG_X_HIGH    = 3'd1;
   localparam logic [2:0] REG_Y_LOW     = 3'd2;
   localparam logic [2:0] REG_Y_HIGH    = 3'd3;
   localparam logic [2:0] REG_CELL_SIZE = 3'd4;

   // Which quotient the shared divider is producing.
   typedef enum logic [1:0] {
      SEL_X,
      SEL_Y,
      SEL_R
   } div_sel_type;

   typedef struct packed {
      logic [1:0]                func;
      logic [7:0]                actor_index;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [15:0]               radius;
   } req_type;

   typedef struct packed {
      logic [BLK_W-1:0]     block_number;
      logic [WORD_BITS-1:0] actor_mask;
      logic                 in_range;
      logic                 last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load_req;
      logic             clr_step;
      logic             prep;
      logic             div_start;
      div_sel_type      sel;
      logic             win;
      logic             rd_ins;
      logic             wr_ins;
      logic             scan_init;
      logic             scan_step;
      logic             out_load;
      logic [BLK_W-1:0] blk;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       clr_last;
      logic [1:0] func;
      logic       pos_ok;
      logic       actor_ok;
      logic       div_done;
      logic       scan_done;
      logic       rsp_full;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/bitmask_spatial_grid_query.sv @@
// Top level of the bitmask spatial grid query block.
// The block keeps a column mask and a row mask per grid cell, one 64-bit
// word per block of 64 actors. Words enter on the req channel
// (valid/ready); func selects clear, insert or query. A query returns four
// words on the rsp channel (valid/ready), block 0 first, with last on the
// final word. Clear and insert return nothing. Configuration registers are
// written through csr_we, csr_index and csr_wdata; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Cell indexes and the reach come from one shared restoring divider of
// 16 + log2(GRID_CELLS) bits that produces one quotient bit per cycle.
// A query outside the area skips the divider and emits its words at once.
// One word is handled at a time; req_ready rises again when it is done.
// After reset, and for each clear, a pass zeroes both stores one address
// a cycle, during which req_ready stays low. A stalled receiver holds the
// output register; the block computes the next word of a query and then
// waits until that register is free.
`default_nettype none
module bitmask_spatial_grid_query import bsgq_pkg::*; #(
   parameter int GRID_CELLS = GRID_CELLS_D
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);

   cmd_type    cmd;
   status_type status;

   bsgq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsgq_datapath #(.GRID_CELLS(GRID_CELLS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ rtl/bsgq_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module bsgq_divider import bsgq_pkg::*; #(
   parameter int NW = 22,
   parameter int DW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               busy,
   output logic               done,
   output logic [NW-1:0]      quotient
);

   localparam int CNT_W = $clog2(NW + 1);

   logic [DW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;

   // One trial subtraction per cycle.
   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/bsgq_datapath.sv @@
// Datapath: configuration, mask stores, cell arithmetic, window scan and output word.
`default_nettype none
module bsgq_datapath import bsgq_pkg::*; #(
   parameter int GRID_CELLS = GRID_CELLS_D
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [15:0]   csr_wdata,
   input  wire req_type       req_data,
   input  wire cmd_type       cmd,
   output status_type         status,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data
);

   localparam int CW    = $clog2(GRID_CELLS);
   localparam int AW    = CW + BLK_W;
   localparam int DEPTH = GRID_CELLS * BLOCKS;
   localparam int NW    = COORD_W + CW;
   localparam int DW    = COORD_W;
   localparam logic [CW+1:0] LAST_CELL = (CW+2)'(GRID_CELLS - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   // Configuration registers.
   logic signed [15:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic [15:0]        cell_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff     <= -16'sd1024;
         x_high_ff    <= 16'sd1023;
         y_low_ff     <= -16'sd1024;
         y_high_ff    <= 16'sd1023;
         cell_size_ff <= 16'd32;
      end else if (csr_we) begin
         case (csr_index)
            REG_X_LOW:     x_low_ff     <= csr_wdata;
            REG_X_HIGH:    x_high_ff    <= csr_wdata;
            REG_Y_LOW:     y_low_ff     <= csr_wdata;
            REG_Y_HIGH:    y_high_ff    <= csr_wdata;
            REG_CELL_SIZE: cell_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Latched request word.
   req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // Position checks and offsets from the low bounds.
   logic        pos_ok;
   logic [16:0] dx, dy, span_x, span_y;
   always_comb begin
      pos_ok = (req_ff.pos_x >= x_low_ff) && (req_ff.pos_x <= x_high_ff) &&
               (req_ff.pos_y >= y_low_ff) && (req_ff.pos_y <= y_high_ff);
      dx     = {req_ff.pos_x[15], req_ff.pos_x} - {x_low_ff[15], x_low_ff};
      dy     = {req_ff.pos_y[15], req_ff.pos_y} - {y_low_ff[15], y_low_ff};
      span_x = {x_high_ff[15], x_high_ff} - {x_low_ff[15], x_low_ff};
      span_y = {y_high_ff[15], y_high_ff} - {y_low_ff[15], y_low_ff};
   end

   // Divider operands, registered after the scaling multiply.
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   always_comb begin
      case (cmd.sel)
         SEL_X: begin
            num_in = NW'(dx[15:0]) * NW'(GRID_CELLS - 1);
            den_in = span_x[15:0];
         end
         SEL_Y: begin
            num_in = NW'(dy[15:0]) * NW'(GRID_CELLS - 1);
            den_in = span_y[15:0];
         end
         default: begin
            num_in = NW'(req_ff.radius);
            den_in = cell_size_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   logic          div_busy, div_done;
   logic [NW-1:0] quo;

   bsgq_divider #(.NW(NW), .DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (num_ff),
      .den      (den_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quo)
   );

   // Capture cell indexes and reach; a zero span maps to cell 0, a zero
   // cell size yields an all-ones quotient and so a full reach.
   logic [CW-1:0] cx_ff, cy_ff, cell_q;
   logic [CW:0]   reach_ff, reach_q;
   always_comb begin
      if (den_ff == '0) begin
         cell_q = '0;
      end else if (quo > NW'(GRID_CELLS - 1)) begin
         cell_q = CW'(GRID_CELLS - 1);
      end else begin
         cell_q = quo[CW-1:0];
      end
      if (quo >= NW'(GRID_CELLS)) begin
         reach_q = (CW+1)'(GRID_CELLS);
      end else begin
         reach_q = quo[CW:0];
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (cmd.sel)
            SEL_X:   cx_ff    <= cell_q;
            SEL_Y:   cy_ff    <= cell_q;
            default: reach_ff <= reach_q;
         endcase
      end
   end

   // Window bounds clipped to the grid.
   logic [CW-1:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic [CW+1:0] cxe, cye, re, xs, ys;
   always_comb begin
      cxe = (CW+2)'(cx_ff);
      cye = (CW+2)'(cy_ff);
      re  = (CW+2)'(reach_ff);
      xs  = cxe + re;
      ys  = cye + re;
   end

   always_ff @(posedge clock) begin
      if (cmd.win) begin
         xlo_ff <= (cxe >= re) ? CW'(cxe - re) : '0;
         ylo_ff <= (cye >= re) ? CW'(cye - re) : '0;
         xhi_ff <= (xs > LAST_CELL) ? LAST_CELL[CW-1:0] : xs[CW-1:0];
         yhi_ff <= (ys > LAST_CELL) ? LAST_CELL[CW-1:0] : ys[CW-1:0];
      end
   end

   // Window scan pointers, one column and one row read per cycle.
   logic [CW-1:0] ci_ff, ri_ff;
   logic          col_more_ff, row_more_ff, col_rv_ff, row_rv_ff;
   logic          col_issue, row_issue;
   always_comb begin
      col_issue = cmd.scan_step && col_more_ff;
      row_issue = cmd.scan_step && row_more_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         ci_ff <= xlo_ff;
         ri_ff <= ylo_ff;
      end else begin
         if (col_issue) begin
            ci_ff <= ci_ff + CW'(1);
         end
         if (row_issue) begin
            ri_ff <= ri_ff + CW'(1);
         end
      end
      if (reset) begin
         col_more_ff <= 1'b0;
         row_more_ff <= 1'b0;
         col_rv_ff   <= 1'b0;
         row_rv_ff   <= 1'b0;
      end else begin
         col_rv_ff <= col_issue;
         row_rv_ff <= row_issue;
         if (cmd.scan_init) begin
            col_more_ff <= 1'b1;
            row_more_ff <= 1'b1;
         end else begin
            if (col_issue && ci_ff == xhi_ff) begin
               col_more_ff <= 1'b0;
            end
            if (row_issue && ri_ff == yhi_ff) begin
               row_more_ff <= 1'b0;
            end
         end
      end
   end

   // Clear pass address.
   logic [AW-1:0] clr_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_addr_ff <= (clr_addr_ff == LAST_ADDR) ? '0 : clr_addr_ff + AW'(1);
      end
   end

   // Mask stores: one write and one read per cycle each.
   logic [WORD_BITS-1:0] col_mem [DEPTH];
   logic [WORD_BITS-1:0] row_mem [DEPTH];
   logic [WORD_BITS-1:0] col_rd_ff, row_rd_ff, ins_bit;
   logic [AW-1:0]        col_raddr, row_raddr, col_iaddr, row_iaddr, col_waddr, row_waddr;
   logic [BLK_W-1:0]     ablk;
   logic                 mem_we;
   logic [WORD_BITS-1:0] col_wdata, row_wdata;

   always_comb begin
      ablk      = req_ff.actor_index[BIT_W+BLK_W-1:BIT_W];
      ins_bit   = WORD_BITS'(1) << req_ff.actor_index[BIT_W-1:0];
      col_iaddr = {cx_ff, ablk};
      row_iaddr = {cy_ff, ablk};
      col_raddr = cmd.rd_ins ? col_iaddr : {ci_ff, cmd.blk};
      row_raddr = cmd.rd_ins ? row_iaddr : {ri_ff, cmd.blk};
      mem_we    = cmd.clr_step || cmd.wr_ins;
      col_waddr = cmd.clr_step ? clr_addr_ff : col_iaddr;
      row_waddr = cmd.clr_step ? clr_addr_ff : row_iaddr;
      col_wdata = cmd.clr_step ? '0 : (col_rd_ff | ins_bit);
      row_wdata = cmd.clr_step ? '0 : (row_rd_ff | ins_bit);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         col_mem[col_waddr] <= col_wdata;
         row_mem[row_waddr] <= row_wdata;
      end
      if (cmd.rd_ins || col_issue) begin
         col_rd_ff <= col_mem[col_raddr];
      end
      if (cmd.rd_ins || row_issue) begin
         row_rd_ff <= row_mem[row_raddr];
      end
   end

   // OR accumulation over the window.
   logic [WORD_BITS-1:0] col_acc_ff, row_acc_ff;
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         col_acc_ff <= '0;
         row_acc_ff <= '0;
      end else begin
         if (col_rv_ff) begin
            col_acc_ff <= col_acc_ff | col_rd_ff;
         end
         if (row_rv_ff) begin
            row_acc_ff <= row_acc_ff | row_rd_ff;
         end
      end
   end

   // Output word register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.block_number <= cmd.blk;
         rsp_data_ff.actor_mask   <= pos_ok ? (col_acc_ff & row_acc_ff) : '0;
         rsp_data_ff.in_range     <= pos_ok;
         rsp_data_ff.last         <= (cmd.blk == BLK_W'(BLOCKS - 1));
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status.clr_last  = (clr_addr_ff == LAST_ADDR);
      status.func      = req_ff.func;
      status.pos_ok    = pos_ok;
      status.actor_ok  = ({1'b0, req_ff.actor_index} < 9'(CAPACITY));
      status.div_done  = div_done;
      status.scan_done = !col_more_ff && !row_more_ff && !col_rv_ff && !row_rv_ff;
      status.rsp_full  = rsp_valid_ff;
   end

   // A new word is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff)
      else $error("output word overwritten");

   // A word outside the area carries an empty mask.
   a_out_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.in_range || rsp_data_ff.actor_mask == '0))
      else $error("nonzero mask for out-of-range query");

   // The scan and the operand load never overlap a running division.
   a_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_init || cmd.prep || cmd.win) |-> !div_busy)
      else $error("datapath step during division");

   // The column scan pointer stays inside the window while column reads are issued.
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      col_issue |-> (ci_ff >= xlo_ff && ci_ff <= xhi_ff))
      else $error("column scan outside window");

endmodule
`default_nettype wire

@@ rtl/bsgq_ctrl.sv @@
// Controller state machine sequencing clear, insert and query operations.
`default_nettype none
module bsgq_ctrl import bsgq_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_PREP,
      S_DIV_GO,
      S_DIV_WAIT,
      S_WIN,
      S_INS_RD,
      S_INS_WR,
      S_SCAN_INIT,
      S_SCAN,
      S_OUT
   } state_type;

   state_type        state_ff, state_in;
   div_sel_type      sel_ff, sel_in;
   logic [BLK_W-1:0] blk_ff, blk_in;

   // Next state and one-cycle commands.
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      blk_in    = blk_ff;
      cmd       = '0;
      cmd.sel   = sel_ff;
      cmd.blk   = blk_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            sel_in = SEL_X;
            blk_in = '0;
            case (status.func)
               FUNC_CLEAR:  state_in = S_CLEAR;
               FUNC_INSERT: state_in = (status.pos_ok && status.actor_ok) ? S_PREP : S_IDLE;
               FUNC_QUERY:  state_in = status.pos_ok ? S_PREP : S_OUT;
               default:     state_in = S_IDLE;
            endcase
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               case (sel_ff)
                  SEL_X: begin
                     sel_in   = SEL_Y;
                     state_in = S_PREP;
                  end
                  SEL_Y: begin
                     if (status.func == FUNC_INSERT) begin
                        state_in = S_INS_RD;
                     end else begin
                        sel_in   = SEL_R;
                        state_in = S_PREP;
                     end
                  end
                  default: state_in = S_WIN;
               endcase
            end
         end
         S_WIN: begin
            cmd.win  = 1'b1;
            state_in = S_SCAN_INIT;
         end
         S_INS_RD: begin
            cmd.rd_ins = 1'b1;
            state_in   = S_INS_WR;
         end
         S_INS_WR: begin
            cmd.wr_ins = 1'b1;
            state_in   = S_IDLE;
         end
         S_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!status.rsp_full) begin
               cmd.out_load = 1'b1;
               if (blk_ff == BLK_W'(BLOCKS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  blk_in   = blk_ff + BLK_W'(1);
                  state_in = status.pos_ok ? S_SCAN_INIT : S_OUT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sel_ff   <= SEL_X;
         blk_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         blk_ff   <= blk_in;
      end
   end

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the bitmask spatial grid query block.
`default_nettype none
module tb_top;
   import bsgq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   bitmask_spatial_grid_query dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the grid configuration and stores.
   int             x_lo, x_hi, y_lo, y_hi;
   int unsigned    cell_w;
   logic [63:0]    col_store [CELLS][BLOCKS];
   logic [63:0]    row_store [CELLS][BLOCKS];
   req_type        pending_words[$];
   rsp_type        expected_words[$];
   int             errors = 0;
   bit             hold_sender = 1'b0;
   bit             long_stall = 1'b0;

   function automatic int grid_cell(int c, int lo, int hi);
      longint span, idx;
      span = longint'(hi) - longint'(lo);
      if (span <= 0) return 0;
      idx = ((longint'(c) - longint'(lo)) * (CELLS - 1)) / span;
      if (idx > CELLS - 1) idx = CELLS - 1;
      if (idx < 0) idx = 0;
      return int'(idx);
   endfunction

   // Apply one accepted word to the mirror and queue any result words.
   task automatic predict_grid(req_type w);
      int px, py, reach, cx, cy, xa, xb, ya, yb, blk;
      bit ok;
      logic [63:0] cols, rows;
      rsp_type r;
      px = int'(w.pos_x);
      py = int'(w.pos_y);
      ok = px >= x_lo && px <= x_hi && py >= y_lo && py <= y_hi;
      case (w.func)
         FUNC_CLEAR: begin
            foreach (col_store[i, j]) begin
               col_store[i][j] = '0;
               row_store[i][j] = '0;
            end
         end
         FUNC_INSERT: begin
            if (ok) begin
               cx = grid_cell(px, x_lo, x_hi);
               cy = grid_cell(py, y_lo, y_hi);
               col_store[cx][w.actor_index / 64][w.actor_index % 64] = 1'b1;
               row_store[cy][w.actor_index / 64][w.actor_index % 64] = 1'b1;
            end
         end
         FUNC_QUERY: begin
            if (cell_w == 0 || w.radius / cell_w >= CELLS) reach = CELLS;
            else reach = int'(w.radius / cell_w);
            cx = grid_cell(px, x_lo, x_hi);
            cy = grid_cell(py, y_lo, y_hi);
            xa = (cx - reach < 0) ? 0 : cx - reach;
            xb = (cx + reach > CELLS - 1) ? CELLS - 1 : cx + reach;
            ya = (cy - reach < 0) ? 0 : cy - reach;
            yb = (cy + reach > CELLS - 1) ? CELLS - 1 : cy + reach;
            for (blk = 0; blk < BLOCKS; blk++) begin
               cols = '0;
               rows = '0;
               for (int i = xa; i <= xb; i++) cols |= col_store[i][blk];
               for (int i = ya; i <= yb; i++) rows |= row_store[i][blk];
               r.block_number = blk[BLK_W-1:0];
               r.actor_mask = ok ? (cols & rows) : '0;
               r.in_range = ok;
               r.last = (blk == BLOCKS - 1);
               expected_words.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   // Driver: bursts of words with random gaps.
   int gap = 0;
   int burst = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // Hold the offered word until it is taken.
      end else begin
         if (req_valid) predict_grid(req_data);
         if (gap > 0) begin
            gap <= gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0 && !hold_sender) begin
            req_data <= pending_words.pop_front();
            req_valid <= 1'b1;
            if (burst <= 0) begin
               burst <= $urandom_range(1, 12);
               gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst <= burst - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each result word with the oldest expectation.
   int stall_phase = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %p", rsp_data);
            errors++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_data.block_number !== e.block_number) begin
               $error("block_number: expected %0d, got %0d", e.block_number,
                      rsp_data.block_number);
               errors++;
            end
            if (rsp_data.actor_mask !== e.actor_mask) begin
               $error("actor_mask: expected %h, got %h", e.actor_mask,
                      rsp_data.actor_mask);
               errors++;
            end
            if (rsp_data.in_range !== e.in_range) begin
               $error("in_range: expected %b, got %b", e.in_range, rsp_data.in_range);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last: expected %b, got %b", e.last, rsp_data.last);
               errors++;
            end
         end
      end
      // Receiver stall pattern: runs of steady ready, otherwise random stalls; all stall while long_stall is set.
      stall_phase <= stall_phase + 1;
      if (long_stall) rsp_ready <= 1'b0;
      else if (stall_phase[7:6] == 2'b11) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   function automatic req_type rand_word(int pct_query);
      req_type w;
      int sel;
      w.actor_index = 8'($urandom_range(0, 255));
      w.pos_x = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2400) - 1200);
      w.pos_y = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2400) - 1200);
      w.radius = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300));
      sel = $urandom_range(0, 99);
      if (sel < 2) w.func = FUNC_CLEAR;
      else if (sel < 4) w.func = FUNC_NONE;
      else if (sel < 4 + pct_query) w.func = FUNC_QUERY;
      else w.func = FUNC_INSERT;
      return w;
   endfunction

   function automatic req_type make_word(logic [1:0] f, logic [7:0] a, int x, int y,
                                         int r);
      req_type w;
      w.func = f;
      w.actor_index = a;
      w.pos_x = 16'(x);
      w.pos_y = 16'(y);
      w.radius = 16'(r);
      return w;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_X_LOW:  x_lo = int'(signed'(val));
         REG_X_HIGH: x_hi = int'(signed'(val));
         REG_Y_LOW:  y_lo = int'(signed'(val));
         REG_Y_HIGH: y_hi = int'(signed'(val));
         default:    cell_w = {16'd0, val};
      endcase
   endtask

   // Wait until all words are taken and every result has come, then settle.
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic set_area(int xl, int xh, int yl, int yh, int cs);
      csr_write(REG_X_LOW, 16'(xl));
      csr_write(REG_X_HIGH, 16'(xh));
      csr_write(REG_Y_LOW, 16'(yl));
      csr_write(REG_Y_HIGH, 16'(yh));
      csr_write(REG_CELL_SIZE, 16'(cs));
   endtask

   task automatic random_phase(int count, int pct_query);
      for (int i = 0; i < count; i++) pending_words.push_back(rand_word(pct_query));
   endtask

   initial begin
      x_lo = -1024; x_hi = 1023; y_lo = -1024; y_hi = 1023; cell_w = 32;
      foreach (col_store[i, j]) begin
         col_store[i][j] = '0;
         row_store[i][j] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // Directed: extremes, every operation and the special cases.
      pending_words.push_back(make_word(FUNC_QUERY, 0, 0, 0, 0));
      pending_words.push_back(make_word(FUNC_INSERT, 0, -1024, -1024, 0));
      pending_words.push_back(make_word(FUNC_INSERT, 255, 1023, 1023, 0));
      pending_words.push_back(make_word(FUNC_INSERT, 64, 0, 0, 0));
      pending_words.push_back(make_word(FUNC_INSERT, 64, 500, -500, 0));
      pending_words.push_back(make_word(FUNC_INSERT, 130, 1024, 0, 0));
      pending_words.push_back(make_word(FUNC_INSERT, 131, -32768, 32767, 0));
      pending_words.push_back(make_word(FUNC_NONE, 8'hff, -1, -1, 16'hffff));
      pending_words.push_back(make_word(FUNC_QUERY, 8'hff, -1024, -1024, 0));
      pending_words.push_back(make_word(FUNC_QUERY, 0, 1023, 1023, 31));
      pending_words.push_back(make_word(FUNC_QUERY, 0, 0, 0, 65535));
      pending_words.push_back(make_word(FUNC_QUERY, 0, 500, -500, 64));
      pending_words.push_back(make_word(FUNC_QUERY, 0, 32767, -32768, 5));
      pending_words.push_back(make_word(FUNC_CLEAR, 8'hff, -1, -1, 16'hffff));
      pending_words.push_back(make_word(FUNC_QUERY, 0, 0, 0, 65535));
      drain();
      // Long receiver stall while the sender keeps offering words.
      long_stall = 1'b1;
      random_phase(40, 50);
      repeat (3000) @(posedge clock);
      long_stall = 1'b0;
      drain();
      random_phase(110, 35);
      drain();
      // Full 16-bit area, zero cell size.
      set_area(-32768, 32767, -32768, 32767, 0);
      for (int i = 0; i < 50; i++) begin
         req_type w;
         w = rand_word(35);
         w.pos_x = 16'($urandom);
         w.pos_y = 16'($urandom);
         pending_words.push_back(w);
      end
      drain();
      // Inverted bounds with largest cell size, then equal bounds with cell size 1.
      set_area(100, -100, 5, 5, 65535);
      random_phase(20, 40);
      pending_words.push_back(make_word(FUNC_INSERT, 7, 0, 5, 0));
      pending_words.push_back(make_word(FUNC_QUERY, 0, 0, 5, 0));
      drain();
      set_area(5, 5, -7, -7, 1);
      for (int i = 0; i < 30; i++) begin
         req_type w;
         w = rand_word(40);
         if ($urandom_range(0, 1)) begin
            w.pos_x = 16'(5);
            w.pos_y = 16'(-7);
         end
         pending_words.push_back(w);
      end
      drain();
      // Small area with fine cells.
      set_area(-40, 40, 0, 63, 3);
      for (int i = 0; i < 60; i++) begin
         req_type w;
         w = rand_word(35);
         w.pos_x = 16'($urandom_range(0, 90) - 45);
         w.pos_y = 16'($urandom_range(0, 70) - 3);
         w.radius = 16'($urandom_range(0, 40));
         pending_words.push_back(w);
      end
      drain();
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #30ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
